// ===== rtl/plist_pkg.sv =====
`default_nettype none

package plist_pkg;

    localparam int REQ_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - VALUE_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FIRST = 3'd0,
        REQ_INS_LAST  = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_DEL_FIRST = 3'd3,
        REQ_DEL_LAST  = 3'd4,
        REQ_DEL_AT    = 3'd5,
        REQ_DISPLAY   = 3'd6
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE   = 2'd0,
        STS_BADPOS = 2'd1,
        STS_FULL   = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_RESP,
        ST_DISP_RD,
        ST_DISP_LD
    } t_state;

    typedef struct packed {
        logic load_req;
        logic i_init;
        logic i_step;
        logic ram_re;
        logic rd_shift;
        logic ram_we;
        logic wr_ins;
        logic len_inc;
        logic len_dec;
        logic out_load;
        logic out_disp;
    } t_cmd;

    typedef struct packed {
        t_status status;
        logic    is_ins;
        logic    is_disp;
        logic    more;
        logic    disp_last;
        logic    out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/plist_ram.sv =====
`default_nettype none

module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/plist_ctrl.sv =====
`default_nettype none

module plist_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire plist_pkg::t_stat i_stat,
    output plist_pkg::t_cmd      o_cmd
);

    plist_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plist_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            plist_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = plist_pkg::ST_EXEC;
                end
            end
            plist_pkg::ST_EXEC: begin
                if (i_stat.status != plist_pkg::STS_DONE) begin
                    n_state = plist_pkg::ST_RESP;
                end else if (i_stat.is_disp) begin
                    o_cmd.i_init = 1'b1;
                    n_state      = plist_pkg::ST_DISP_RD;
                end else begin
                    o_cmd.i_init = 1'b1;
                    n_state      = plist_pkg::ST_LOOP;
                end
            end
            plist_pkg::ST_LOOP: begin
                if (i_stat.more) begin
                    n_state = plist_pkg::ST_SHIFT_RD;
                end else if (i_stat.is_ins) begin
                    n_state = plist_pkg::ST_INS_WR;
                end else begin
                    o_cmd.len_dec = 1'b1;
                    n_state       = plist_pkg::ST_RESP;
                end
            end
            plist_pkg::ST_SHIFT_RD: begin
                o_cmd.ram_re   = 1'b1;
                o_cmd.rd_shift = 1'b1;
                n_state        = plist_pkg::ST_SHIFT_WR;
            end
            plist_pkg::ST_SHIFT_WR: begin
                o_cmd.ram_we = 1'b1;
                o_cmd.i_step = 1'b1;
                n_state      = plist_pkg::ST_LOOP;
            end
            plist_pkg::ST_INS_WR: begin
                o_cmd.ram_we  = 1'b1;
                o_cmd.wr_ins  = 1'b1;
                o_cmd.len_inc = 1'b1;
                n_state       = plist_pkg::ST_RESP;
            end
            plist_pkg::ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = plist_pkg::ST_IDLE;
                end
            end
            plist_pkg::ST_DISP_RD: begin
                o_cmd.ram_re = 1'b1;
                n_state      = plist_pkg::ST_DISP_LD;
            end
            plist_pkg::ST_DISP_LD: begin
                // hold the read data until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_disp = 1'b1;
                    if (i_stat.disp_last) begin
                        n_state = plist_pkg::ST_IDLE;
                    end else begin
                        o_cmd.i_step = 1'b1;
                        n_state      = plist_pkg::ST_DISP_RD;
                    end
                end
            end
            default: begin
                n_state = plist_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/plist_dp.sv =====
`default_nettype none

module plist_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [plist_pkg::REQ_W-1:0]    i_req,
    input  wire logic [plist_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [plist_pkg::POS_W-1:0]    i_pos,
    input  wire logic                           i_m_tready,
    input  wire plist_pkg::t_cmd                i_cmd,
    output plist_pkg::t_stat                    o_stat,
    output logic                                o_out_valid,
    output logic [plist_pkg::STATUS_W-1:0]      o_out_status,
    output logic [plist_pkg::COUNT_W-1:0]       o_out_count,
    output logic [plist_pkg::VALUE_W-1:0]       o_out_value,
    output logic                                o_out_last
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = ((IW > plist_pkg::POS_W) ? IW : plist_pkg::POS_W) + 1;

    plist_pkg::t_req                 r_req;
    logic [plist_pkg::VALUE_W-1:0]   r_value;
    logic [plist_pkg::POS_W-1:0]     r_pos;
    logic [IW-1:0]                   r_len;
    logic [IW-1:0]                   r_i;
    logic                            r_ok;
    logic                            r_out_valid;
    logic [plist_pkg::STATUS_W-1:0]  r_out_status;
    logic [plist_pkg::COUNT_W-1:0]   r_out_count;
    logic [plist_pkg::VALUE_W-1:0]   r_out_value;
    logic                            r_out_last;

    logic [CW-1:0]                   len_c, pos_c, i_c, idx_c;
    logic [IW-1:0]                   idx, i_prev, i_next;
    logic [31:0]                     len32;
    plist_pkg::t_status              status;
    logic                            is_ins, is_disp;
    logic [AW-1:0]                   raddr, waddr;
    logic [plist_pkg::VALUE_W-1:0]   wdata, rdata;

    assign len_c  = CW'(r_len);
    assign pos_c  = CW'(r_pos);
    assign i_c    = CW'(r_i);
    assign i_prev = r_i - IW'(1);
    assign i_next = r_i + IW'(1);
    assign len32  = 32'(r_len);

    always_comb begin
        status  = plist_pkg::STS_DONE;
        is_ins  = 1'b0;
        is_disp = 1'b0;
        idx_c   = '0;
        unique case (r_req) inside
            plist_pkg::REQ_INS_FIRST, plist_pkg::REQ_INS_LAST, plist_pkg::REQ_INS_AT: begin
                is_ins = 1'b1;
                if (r_req == plist_pkg::REQ_INS_LAST) begin
                    idx_c = len_c;
                end else if (r_req == plist_pkg::REQ_INS_AT) begin
                    idx_c = pos_c - CW'(1);
                end
                // full check wins over the position check
                if (len_c >= CW'(CAPACITY)) begin
                    status = plist_pkg::STS_FULL;
                end else if (r_req == plist_pkg::REQ_INS_AT &&
                             (pos_c == '0 || pos_c > len_c + CW'(1))) begin
                    status = plist_pkg::STS_BADPOS;
                end
            end
            plist_pkg::REQ_DEL_FIRST, plist_pkg::REQ_DEL_LAST, plist_pkg::REQ_DEL_AT: begin
                if (r_req == plist_pkg::REQ_DEL_LAST) begin
                    idx_c = len_c - CW'(1);
                end else if (r_req == plist_pkg::REQ_DEL_AT) begin
                    idx_c = pos_c - CW'(1);
                end
                if (len_c == '0) begin
                    status = plist_pkg::STS_EMPTY;
                end else if (r_req == plist_pkg::REQ_DEL_AT &&
                             (pos_c == '0 || pos_c > len_c)) begin
                    status = plist_pkg::STS_BADPOS;
                end
            end
            plist_pkg::REQ_DISPLAY: begin
                is_disp = 1'b1;
                if (len_c == '0) begin
                    status = plist_pkg::STS_EMPTY;
                end
            end
            default: begin
                status = plist_pkg::STS_BADPOS;
            end
        endcase
    end

    assign idx = idx_c[IW-1:0];

    always_comb begin
        o_stat.status    = status;
        o_stat.is_ins    = is_ins;
        o_stat.is_disp   = is_disp;
        o_stat.more      = is_ins ? (r_i > idx) : (i_c + CW'(1) < len_c);
        o_stat.disp_last = (i_c + CW'(1) == len_c);
        o_stat.out_free  = !r_out_valid || i_m_tready;
    end

    // shift moves toward the back on insert, toward the front on delete
    always_comb begin
        if (i_cmd.rd_shift) begin
            raddr = is_ins ? i_prev[AW-1:0] : i_next[AW-1:0];
        end else begin
            raddr = r_i[AW-1:0];
        end
        waddr = i_cmd.wr_ins ? idx[AW-1:0] : r_i[AW-1:0];
        wdata = i_cmd.wr_ins ? r_value : rdata;
    end

    plist_ram #(
        .WIDTH (plist_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= plist_pkg::t_req'(i_req);
            r_value <= i_value;
            r_pos   <= i_pos;
            r_ok    <= 1'b0;
        end
        if (i_cmd.i_init) begin
            r_i  <= is_ins ? r_len : (is_disp ? '0 : idx);
            r_ok <= 1'b1;
        end else if (i_cmd.i_step) begin
            r_i <= is_ins ? i_prev : i_next;
        end
        if (i_cmd.out_load) begin
            r_out_count <= len32[plist_pkg::COUNT_W-1:0];
            if (i_cmd.out_disp) begin
                r_out_status <= plist_pkg::STS_DONE;
                r_out_value  <= rdata;
                r_out_last   <= o_stat.disp_last;
            end else begin
                // the live status follows the new count; hold done once the list moved
                r_out_status <= r_ok ? plist_pkg::STS_DONE : status;
                r_out_value  <= '0;
                r_out_last   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.len_inc) begin
                r_len <= r_len + IW'(1);
            end else if (i_cmd.len_dec) begin
                r_len <= r_len - IW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_count  = r_out_count;
    assign o_out_value  = r_out_value;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values, one request at a time.
// Requests enter on the slave stream (kind in tuser, value and position in
// tdata); results leave on the master stream through an output register, so a
// new request is taken while the last result still waits. The entries sit in
// a single-port-write, registered-read memory. A request that moves n
// entries (insert at a position ahead of n entries, or delete with n entries
// behind it) walks each moved entry through a read, a write and a loop
// check; a display reads each entry and loads it into the output register
// once that register is free. No clearing is needed after reset: only
// entries below the count are ever read.
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [31:0] value, [39:32] position
    input  wire logic [plist_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [2:0] req_type
    input  wire logic [plist_pkg::REQ_W-1:0]         i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [4:0] entry_count, [36:5] entry_value, [39:37] zero
    output logic [plist_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // [1:0] status
    output logic [plist_pkg::STATUS_W-1:0]           o_m_tuser,
    output logic                                     o_m_tlast
);

    plist_pkg::t_cmd                cmd;
    plist_pkg::t_stat               stat;
    logic [plist_pkg::COUNT_W-1:0]  out_count;
    logic [plist_pkg::VALUE_W-1:0]  out_value;

    plist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    plist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_s_tuser),
        .i_value      (i_s_tdata[plist_pkg::VALUE_W-1:0]),
        .i_pos        (i_s_tdata[plist_pkg::VALUE_W +: plist_pkg::POS_W]),
        .i_m_tready   (i_m_tready),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_m_tvalid),
        .o_out_status (o_m_tuser),
        .o_out_count  (out_count),
        .o_out_value  (out_value),
        .o_out_last   (o_m_tlast)
    );

    assign o_m_tdata = {{plist_pkg::OUT_PAD_W{1'b0}}, out_value, out_count};

    // one request in flight: no second request right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in flight");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten before it was taken");

    a_ram_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.ram_we && cmd.ram_re))
        else $error("memory read and write in the same cycle");

    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != plist_pkg::STS_DONE |-> o_m_tlast)
        else $error("error result not marked final");

endmodule

`default_nettype wire
